[sv/assert_macros.svh]
// Assertion macros shared by the trend pattern counter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Plain property, sampled on clk and switched off while in reset.
`define TKMP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Implication checked in the same cycle.
`define TKMP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define TKMP_ASSERT(label, prop, msg)
`define TKMP_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

[sv/tkmp_pkg.sv]
// Package with constants, types and helpers of the trend pattern counter.
package tkmp_pkg;

    // Sizing of the pattern and of the sample comparison.
    localparam int PAT_MAX      = 16;
    localparam int VALUE_BITS   = 32;
    localparam int SYMS_LIMIT   = (PAT_MAX < 16) ? PAT_MAX : 16;
    localparam int TBL_DEPTH    = 16;
    localparam int TBL_IDX_BITS = 4;
    localparam int LEN_BITS     = 5;
    localparam int SAMPLE_BITS  = 32;
    localparam int TOTAL_BITS   = 32;
    localparam int CODES_BITS   = 32;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_CODES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PATTERN_LEN   = 2'd1;

    // Trend symbol codes.
    localparam logic [1:0] SYM_DOWN  = 2'd0;
    localparam logic [1:0] SYM_EQUAL = 2'd1;
    localparam logic [1:0] SYM_UP    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_WALK
    } tkmp_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_cfg;
        logic build_step;
        logic accept_item;
        logic walk_step;
    } tkmp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic build_done;
        logic walk_last;
        logic slot_free;
    } tkmp_status_t;

    // Pattern length in use: zero counts as one, large values saturate.
    function automatic logic [LEN_BITS-1:0] eff_len(input logic [LEN_BITS-1:0] len);
        logic [LEN_BITS-1:0] n;
        begin
            n = len;
            if (n == '0)
            begin
                n = LEN_BITS'(1);
            end
            if (n > LEN_BITS'(SYMS_LIMIT))
            begin
                n = LEN_BITS'(SYMS_LIMIT);
            end
            return n;
        end
    endfunction

    // Symbol i of the packed pattern.
    function automatic logic [1:0] sym_at(input logic [CODES_BITS-1:0] codes,
                                          input logic [TBL_IDX_BITS-1:0] i);
        begin
            return codes[{i, 1'b0} +: 2];
        end
    endfunction

endpackage

[sv/tkmp_sample_if.sv]
// Input channel carrying one sample transaction.
interface tkmp_sample_if;
    import tkmp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   start_of_sequence;

    modport source (output valid, output sample_value, output start_of_sequence,
                    input ready);
    modport sink   (input valid, input sample_value, input start_of_sequence,
                    output ready);
endinterface

[sv/tkmp_result_if.sv]
// Output channel carrying one result transaction.
interface tkmp_result_if;
    import tkmp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  match_here;
    logic [TOTAL_BITS-1:0] match_total;

    modport source (output valid, output match_here, output match_total, input ready);
    modport sink   (input valid, input match_here, input match_total, output ready);
endinterface

[sv/tkmp_cfg_if.sv]
// Configuration write channel.
interface tkmp_cfg_if;
    import tkmp_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/trend_pattern_kmp_counter_core.sv]
// Top level of the trend pattern counter: channels, controller and datapath.
// An accepted item follows one failure link per walk step, and its result is registered
// when the output register is free; no new item is taken before that. A write to the pattern
// codes or length clears and rebuilds the prefix table; nothing is taken during the rebuild.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n, asynchronous, active low) gives pattern 0, length 1, zero total, no previous.
`include "assert_macros.svh"

module trend_pattern_kmp_counter_core
    import tkmp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    tkmp_sample_if.sink   sample,
    tkmp_result_if.source result,
    tkmp_cfg_if.sink      cfg
);

    tkmp_cmd_t    cmd;
    tkmp_status_t status;

    tkmp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_ready (cfg.ready),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tkmp_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_index         (cfg.index),
        .cfg_data          (cfg.data),
        .sample_value      (sample.sample_value),
        .start_of_sequence (sample.start_of_sequence),
        .out_valid         (result.valid),
        .out_ready         (result.ready),
        .match_here        (result.match_here),
        .match_total       (result.match_total)
    );

    `TKMP_ASSERT_IMP(a_accept_cmd, sample.valid && sample.ready, cmd.accept_item, "lost accept")

endmodule

[sv/tkmp_datapath.sv]
// Datapath: pattern registers, prefix table, trend symbol and match walk.
`include "assert_macros.svh"

module tkmp_datapath
    import tkmp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tkmp_cmd_t                cmd,
    output tkmp_status_t             status,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic [SAMPLE_BITS-1:0]   sample_value,
    input  logic                     start_of_sequence,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     match_here,
    output logic [TOTAL_BITS-1:0]    match_total
);

    logic [CODES_BITS-1:0]  pattern_codes_reg;
    logic [LEN_BITS-1:0]    pattern_len_reg;
    logic [VALUE_BITS-1:0]  prev_reg;
    logic                   have_prev_reg;
    logic [LEN_BITS-1:0]    matched_reg;
    logic [LEN_BITS-1:0]    prefix_reg [TBL_DEPTH];
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [1:0]             sym_reg;
    logic                   no_trend_reg;
    logic [LEN_BITS-1:0]    k_reg;
    logic [LEN_BITS-1:0]    build_i_reg;
    logic [LEN_BITS-1:0]    build_k_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [TOTAL_BITS-1:0]  out_total_reg;

    logic [LEN_BITS-1:0]    len_eff;
    logic [VALUE_BITS-1:0]  cur_value;
    logic [1:0]             trend;
    logic                   have_eff;
    logic [LEN_BITS-1:0]    k_start;
    logic [1:0]             walk_sym;
    logic                   walk_mismatch;
    logic [LEN_BITS-1:0]    walk_next;
    logic                   walk_hit;
    logic [LEN_BITS-1:0]    walk_fail;
    logic [LEN_BITS-1:0]    walk_final_k;
    logic [TOTAL_BITS-1:0]  total_inc;
    logic [1:0]             build_sym_i;
    logic [1:0]             build_sym_k;
    logic                   build_mismatch;
    logic [LEN_BITS-1:0]    build_next;
    logic [LEN_BITS-1:0]    build_fail;
    logic [LEN_BITS-1:0]    end_link;

    // Trend symbol from the signed comparison with the previous sample, and the walk start.
    always_comb
    begin
        len_eff   = eff_len(pattern_len_reg);
        cur_value = sample_value[VALUE_BITS-1:0];
        if ($signed(cur_value) > $signed(prev_reg))
        begin
            trend = SYM_UP;
        end
        else if ($signed(cur_value) < $signed(prev_reg))
        begin
            trend = SYM_DOWN;
        end
        else
        begin
            trend = SYM_EQUAL;
        end
        have_eff = have_prev_reg && !start_of_sequence;
        if (start_of_sequence || (matched_reg >= len_eff))
        begin
            k_start = '0;
        end
        else
        begin
            k_start = matched_reg;
        end
    end

    // One step of the failure-link walk for the current symbol.
    always_comb
    begin
        walk_sym      = sym_at(pattern_codes_reg, k_reg[TBL_IDX_BITS-1:0]);
        walk_mismatch = (k_reg != '0) && (walk_sym != sym_reg);
        walk_fail     = prefix_reg[TBL_IDX_BITS'(k_reg - LEN_BITS'(1))];
        walk_next     = k_reg + LEN_BITS'(walk_sym == sym_reg);
        walk_hit      = !no_trend_reg && (walk_next >= len_eff);
        end_link      = prefix_reg[TBL_IDX_BITS'(len_eff - LEN_BITS'(1))];
        walk_final_k  = walk_hit ? end_link : walk_next;
        if (walk_hit && (total_reg != '1))
        begin
            total_inc = total_reg + TOTAL_BITS'(1);
        end
        else
        begin
            total_inc = total_reg;
        end
    end

    // One step of the prefix table construction.
    always_comb
    begin
        build_sym_i    = sym_at(pattern_codes_reg, build_i_reg[TBL_IDX_BITS-1:0]);
        build_sym_k    = sym_at(pattern_codes_reg, build_k_reg[TBL_IDX_BITS-1:0]);
        build_mismatch = (build_k_reg != '0) && (build_sym_k != build_sym_i);
        build_fail     = prefix_reg[TBL_IDX_BITS'(build_k_reg - LEN_BITS'(1))];
        build_next     = build_k_reg + LEN_BITS'(build_sym_k == build_sym_i);
    end

    assign status.build_done = (build_i_reg >= len_eff);
    assign status.walk_last  = no_trend_reg || !walk_mismatch;
    assign status.slot_free  = !out_valid_reg || out_ready;

    // Sequence state, pattern registers and prefix table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_codes_reg <= '0;
            pattern_len_reg   <= LEN_BITS'(1);
            prev_reg          <= '0;
            have_prev_reg     <= 1'b0;
            matched_reg       <= '0;
            total_reg         <= '0;
            build_i_reg       <= LEN_BITS'(1);
            build_k_reg       <= '0;
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                prefix_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load_cfg)
            begin
                if (cfg_index == REG_PATTERN_CODES)
                begin
                    pattern_codes_reg <= cfg_data[CODES_BITS-1:0];
                end
                if (cfg_index == REG_PATTERN_LEN)
                begin
                    pattern_len_reg <= cfg_data[LEN_BITS-1:0];
                end
                for (int i = 0; i < TBL_DEPTH; i++)
                begin
                    prefix_reg[i] <= '0;
                end
                build_i_reg <= LEN_BITS'(1);
                build_k_reg <= '0;
                matched_reg <= '0;
            end
            if (cmd.build_step)
            begin
                if (build_mismatch)
                begin
                    build_k_reg <= build_fail;
                end
                else
                begin
                    prefix_reg[build_i_reg[TBL_IDX_BITS-1:0]] <= build_next;
                    build_k_reg <= build_next;
                    build_i_reg <= build_i_reg + LEN_BITS'(1);
                end
            end
            if (cmd.accept_item)
            begin
                prev_reg      <= cur_value;
                have_prev_reg <= 1'b1;
                if (start_of_sequence)
                begin
                    matched_reg <= '0;
                    total_reg   <= '0;
                end
            end
            if (cmd.walk_step && !no_trend_reg && !walk_mismatch)
            begin
                matched_reg <= walk_final_k;
                total_reg   <= total_inc;
            end
        end
    end

    // Item working registers; no reset needed.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_item)
        begin
            sym_reg      <= trend;
            no_trend_reg <= !have_eff;
            k_reg        <= k_start;
        end
        else if (cmd.walk_step && walk_mismatch)
        begin
            k_reg <= walk_fail;
        end
    end

    // Output register: loaded by the last walk step, freed when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.walk_step && status.walk_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_step && status.walk_last)
        begin
            out_hit_reg   <= walk_hit;
            out_total_reg <= no_trend_reg ? total_reg : total_inc;
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_here  = out_hit_reg;
    assign match_total = out_total_reg;

    `TKMP_ASSERT(a_matched_below_len, matched_reg < len_eff, "match length reached pattern length")
    `TKMP_ASSERT_IMP(a_hit_counted, out_valid_reg && out_hit_reg, out_total_reg != '0, "match reported with zero total")
    `TKMP_ASSERT_IMP(a_build_in_range, cmd.build_step, build_i_reg < len_eff, "prefix build stepped past pattern end")

endmodule

[sv/tkmp_ctrl.sv]
// Controller: state machine for configuration, prefix build and match walk.
`include "assert_macros.svh"

module tkmp_ctrl
    import tkmp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    output logic                    cfg_ready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tkmp_status_t            status,
    output tkmp_cmd_t               cmd
);

    tkmp_state_t state_reg;
    tkmp_state_t state_next;
    logic        cfg_known;

    assign cfg_known = (cfg_index == REG_PATTERN_CODES) || (cfg_index == REG_PATTERN_LEN);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cfg_ready  = 1'b0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    if (cfg_known)
                    begin
                        cmd.load_cfg = 1'b1;
                        state_next   = ST_BUILD;
                    end
                end
                else if (in_valid)
                begin
                    cmd.accept_item = 1'b1;
                    state_next      = ST_WALK;
                end
            end
            ST_BUILD:
            begin
                if (status.build_done)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.build_step = 1'b1;
                end
            end
            ST_WALK:
            begin
                cmd.walk_step = !status.walk_last || status.slot_free;
                if (status.walk_last && status.slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `TKMP_ASSERT(a_one_command, $onehot0(cmd), "more than one datapath command")
    `TKMP_ASSERT_IMP(a_no_item_in_build, state_reg == ST_BUILD, !in_ready && !cfg_ready, "handshake open during prefix build")
    `TKMP_ASSERT_IMP(a_walk_leaves_on_emit, cmd.walk_step && status.walk_last, state_next == ST_IDLE, "walk did not end on result")

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the trend pattern counter: random handshakes and a predictor.
module tb_top;
    import tkmp_pkg::*;

    // Register indexes that the block must ignore.
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_3 = 2'd3;
    // Pattern code that no trend can equal.
    localparam logic [1:0] SYM_NONE = 2'd3;

    localparam int     RANDOM_ITEMS  = 1850;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     TIMEOUT_UNITS = 1000000;
    localparam int     LEN_PAD_BITS  = CFG_DATA_BITS - LEN_BITS;
    localparam longint SAMPLE_MAX    = 64'sd2147483647;
    localparam longint SAMPLE_MIN    = -64'sd2147483648;

    typedef struct {
        logic [SAMPLE_BITS-1:0] value;
        logic                   start;
    } sample_item_t;

    typedef struct {
        logic                  match_here;
        logic [TOTAL_BITS-1:0] match_total;
    } trend_result_t;

    logic clk = 1'b0;
    logic rst_n;

    tkmp_sample_if sample_bus ();
    tkmp_result_if result_bus ();
    tkmp_cfg_if    cfg_bus ();

    trend_pattern_kmp_counter_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Clock generation.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stimulus waiting to be sent and results still to arrive.
    sample_item_t  pending_samples[$];
    trend_result_t expected_results[$];
    int            fail_count = 0;

    // Shadow copy of the registers and of the matcher state.
    logic [CODES_BITS-1:0]  pat_codes;
    logic [LEN_BITS-1:0]    pat_len;
    logic [SAMPLE_BITS-1:0] prev_sample;
    logic                   have_prev;
    logic [LEN_BITS-1:0]    match_len;
    logic [LEN_BITS-1:0]    fail_link [TBL_DEPTH];
    logic [TOTAL_BITS-1:0]  seq_total;

    // Handshake pacing of both sides.
    int send_gap   = 0;
    int send_calm  = 0;
    int recv_stall = 0;
    int recv_calm  = 0;

    // Generator state.
    logic [SAMPLE_BITS-1:0] stream_last = '0;
    int                     random_items = 0;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Wait before the next transaction: mostly random, with calm stretches of none.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Number of pattern symbols actually compared.
    function automatic logic [LEN_BITS-1:0] active_len();
        if (pat_len == '0)
        begin
            return LEN_BITS'(1);
        end
        if (pat_len > LEN_BITS'(SYMS_LIMIT))
        begin
            return LEN_BITS'(SYMS_LIMIT);
        end
        return pat_len;
    endfunction

    function automatic logic [1:0] pattern_sym(input logic [LEN_BITS-1:0] i);
        return 2'((pat_codes >> (2 * i[3:0])) & 32'd3);
    endfunction

    // Rebuild the failure links from the shadow registers; the partial match is lost.
    task automatic rebuild_failure_links();
        logic [LEN_BITS-1:0] m;
        logic [LEN_BITS-1:0] k;
        logic [1:0]          s;
        m = active_len();
        k = '0;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            fail_link[i] = '0;
        end
        for (int i = 1; i < m; i++)
        begin
            s = pattern_sym(LEN_BITS'(i));
            while (k != '0 && pattern_sym(k) != s)
            begin
                k = fail_link[TBL_IDX_BITS'(k - 1'b1)];
            end
            if (pattern_sym(k) == s)
            begin
                k++;
            end
            fail_link[i] = k;
        end
        match_len = '0;
    endtask

    task automatic apply_register_write(input logic [CFG_IDX_BITS-1:0] idx,
                                        input logic [CFG_DATA_BITS-1:0] value);
        case (idx)
            REG_PATTERN_CODES:
            begin
                pat_codes = value;
                rebuild_failure_links();
            end
            REG_PATTERN_LEN:
            begin
                pat_len = value[LEN_BITS-1:0];
                rebuild_failure_links();
            end
            default:
            begin
            end
        endcase
    endtask

    // Work out the result of one accepted sample and queue it.
    task automatic predict_trend_match(input logic [SAMPLE_BITS-1:0] value, input logic start);
        trend_result_t       r;
        logic [1:0]          trend;
        logic [LEN_BITS-1:0] m;
        logic [LEN_BITS-1:0] k;
        if (start)
        begin
            prev_sample = '0;
            have_prev   = 1'b0;
            match_len   = '0;
            seq_total   = '0;
        end
        r.match_here = 1'b0;
        if (have_prev)
        begin
            if ($signed(value) > $signed(prev_sample))
            begin
                trend = SYM_UP;
            end
            else if ($signed(value) < $signed(prev_sample))
            begin
                trend = SYM_DOWN;
            end
            else
            begin
                trend = SYM_EQUAL;
            end
            m = active_len();
            k = (match_len >= m) ? '0 : match_len;
            while (k != '0 && pattern_sym(k) != trend)
            begin
                k = fail_link[TBL_IDX_BITS'(k - 1'b1)];
            end
            if (pattern_sym(k) == trend)
            begin
                k++;
            end
            if (k >= m)
            begin
                r.match_here = 1'b1;
                if (seq_total != '1)
                begin
                    seq_total++;
                end
                k = fail_link[TBL_IDX_BITS'(m - 1'b1)];
            end
            match_len = k;
        end
        prev_sample   = value;
        have_prev     = 1'b1;
        r.match_total = seq_total;
        expected_results = {expected_results, r};
    endtask

    // Sample driver: presents queued items, with a random gap after each transaction.
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        sample_item_t item;
        logic         slot_free;
        if (!rst_n)
        begin
            sample_bus.valid             <= 1'b0;
            sample_bus.sample_value      <= '0;
            sample_bus.start_of_sequence <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            slot_free = !sample_bus.valid;
            if (sample_bus.valid && sample_bus.ready)
            begin
                predict_trend_match(sample_bus.sample_value, sample_bus.start_of_sequence);
                send_gap  = draw_wait(send_calm);
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (send_gap != 0)
                begin
                    send_gap--;
                    sample_bus.valid <= 1'b0;
                end
                else if (pending_samples.size() != 0)
                begin
                    item = pending_samples.pop_front();
                    sample_bus.valid             <= 1'b1;
                    sample_bus.sample_value      <= item.value;
                    sample_bus.start_of_sequence <= item.start;
                end
                else
                begin
                    sample_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure and comparison with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        trend_result_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transaction with no prediction pending");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bus.match_here !== want.match_here)
                    begin
                        report_mismatch($sformatf("match_here %b, predicted %b",
                                                  result_bus.match_here, want.match_here));
                    end
                    if (result_bus.match_total !== want.match_total)
                    begin
                        report_mismatch($sformatf("match_total %0d, predicted %0d",
                                                  result_bus.match_total, want.match_total));
                    end
                end
                recv_stall = draw_wait(recv_calm);
            end
            if (recv_stall != 0)
            begin
                recv_stall--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    // One register write; the shadow copy follows at the accepting edge.
    task automatic write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        apply_register_write(idx, value);
        cfg_bus.valid <= 1'b0;
    endtask

    // Let every queued item through and every result out, then let the block settle.
    task automatic wait_until_quiet();
        while (pending_samples.size() != 0 || expected_results.size() != 0 || sample_bus.valid)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] value, input logic start);
        sample_item_t item;
        item.value = value;
        item.start = start;
        pending_samples = {pending_samples, item};
        stream_last = value;
        random_items++;
    endtask

    // A value that forms the requested trend after the given one, near or far from it, where the range allows.
    function automatic logic [SAMPLE_BITS-1:0] sample_with_trend(
        input logic [SAMPLE_BITS-1:0] last,
        input logic [1:0]             trend
    );
        longint p;
        longint span;
        longint offset;
        longint v;
        p = longint'($signed(last));
        v = longint'($signed($urandom));
        if (trend == SYM_UP && p != SAMPLE_MAX)
        begin
            span = SAMPLE_MAX - p;
        end
        else if (trend == SYM_DOWN && p != SAMPLE_MIN)
        begin
            span = p - SAMPLE_MIN;
        end
        else
        begin
            span = 0;
        end
        if (span != 0)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                offset = $urandom_range(0, int'((span < 16) ? span - 1 : 15));
            end
            else
            begin
                offset = longint'($urandom) % span;
            end
            v = (trend == SYM_UP) ? p + 1 + offset : p - 1 - offset;
        end
        else if (trend == SYM_EQUAL)
        begin
            v = p;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] noise_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic start_flag();
        return ($urandom_range(0, 39) == 0);
    endfunction

    // Mostly copies of the pattern, some broken prefixes and some noise.
    task automatic queue_phase_stream(input int count);
        int target;
        int m;
        int cut;
        target = random_items + count;
        m = active_len();
        while (random_items < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    repeat ($urandom_range(1, 3))
                    begin
                        for (int j = 0; j < m; j++)
                        begin
                            queue_sample(sample_with_trend(stream_last,
                                                           pattern_sym(LEN_BITS'(j))),
                                         start_flag());
                        end
                    end
                end
                6, 7:
                begin
                    cut = $urandom_range(0, m - 1);
                    for (int j = 0; j < cut; j++)
                    begin
                        queue_sample(sample_with_trend(stream_last, pattern_sym(LEN_BITS'(j))),
                                     start_flag());
                    end
                    queue_sample(sample_with_trend(stream_last, 2'($urandom_range(0, 2))),
                                 start_flag());
                end
                default:
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        queue_sample(noise_value(), start_flag());
                    end
                end
            endcase
        end
    endtask

    // Periodic patterns give long failure links; a few carry the unmatched code.
    function automatic logic [CODES_BITS-1:0] random_pattern();
        logic [CODES_BITS-1:0] codes;
        logic [1:0]            motif [4];
        int                    motif_len;
        case ($urandom_range(0, 9))
            0:
            begin
                codes = $urandom;
            end
            1, 2, 3, 4:
            begin
                motif_len = $urandom_range(1, 4);
                for (int i = 0; i < 4; i++)
                begin
                    motif[i] = 2'($urandom_range(0, 2));
                end
                for (int i = 0; i < 16; i++)
                begin
                    codes[2*i +: 2] = motif[i % motif_len];
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    codes[2*$urandom_range(0, 15) +: 2] = 2'($urandom_range(0, 2));
                end
            end
            default:
            begin
                for (int i = 0; i < 16; i++)
                begin
                    codes[2*i +: 2] = ($urandom_range(0, 11) == 0) ? SYM_NONE
                                                                    : 2'($urandom_range(0, 2));
                end
            end
        endcase
        return codes;
    endfunction

    function automatic logic [LEN_BITS-1:0] random_length();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return LEN_BITS'($urandom_range(1, 4));
            4, 5, 6, 7: return LEN_BITS'($urandom_range(5, 16));
            8:          return LEN_BITS'($urandom_range(17, 31));
            default:    return '0;
        endcase
    endfunction

    // Main sequence: reset, directed checks, then random phases.
    initial
    begin : stimulus
        logic [LEN_BITS-1:0]      len_value;
        logic [CFG_DATA_BITS-1:0] len_word;
        int                       phase;
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;
        pat_codes   = '0;
        pat_len     = LEN_BITS'(1);
        prev_sample = '0;
        have_prev   = 1'b0;
        seq_total   = '0;
        rebuild_failure_links();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Single down symbol; the first item after reset forms no trend.
        write_register(REG_PATTERN_CODES, '0);
        write_register(REG_PATTERN_LEN, CFG_DATA_BITS'(1));
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h7FFF_FFFF, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h0000_0000, 1'b0);
        queue_sample(32'h0000_0000, 1'b1);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        wait_until_quiet();

        // Unmatchable codes with length zero, written mid-sequence.
        write_register(REG_PATTERN_CODES, 32'hFFFF_FFFF);
        write_register(REG_PATTERN_LEN, '0);
        queue_sample(32'd5, 1'b0);
        queue_sample(32'd7, 1'b0);
        queue_sample(32'd7, 1'b0);
        queue_sample(32'd3, 1'b0);
        wait_until_quiet();

        // Up, equal, up with overlapping matches; unused indexes must change nothing.
        write_register(REG_UNUSED_2, 32'hA5A5_5A5A);
        write_register(REG_PATTERN_CODES, CODES_BITS'(SYM_UP) | (CODES_BITS'(SYM_EQUAL) << 2)
                                          | (CODES_BITS'(SYM_UP) << 4));
        write_register(REG_UNUSED_3, 32'h5A5A_A5A5);
        write_register(REG_PATTERN_LEN, 32'hFFFF_FFE3);
        queue_sample(32'd0, 1'b1);
        queue_sample(32'd1, 1'b0);
        queue_sample(32'd1, 1'b0);
        queue_sample(32'd2, 1'b0);
        queue_sample(32'd2, 1'b0);
        queue_sample(32'd3, 1'b0);
        wait_until_quiet();

        // Random phases; the first ones cover full and oversized lengths.
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase)
                0:       len_value = LEN_BITS'(16);
                1:       len_value = LEN_BITS'(31);
                2:       len_value = LEN_BITS'(17);
                default: len_value = random_length();
            endcase
            len_word = ($urandom_range(0, 1) == 0) ? CFG_DATA_BITS'(len_value)
                                                   : {LEN_PAD_BITS'($urandom), len_value};
            if ($urandom_range(0, 1) == 0)
            begin
                write_register(REG_PATTERN_CODES, random_pattern());
                write_register(REG_PATTERN_LEN, len_word);
            end
            else
            begin
                write_register(REG_PATTERN_LEN, len_word);
                write_register(REG_PATTERN_CODES, random_pattern());
            end
            if ($urandom_range(0, 4) == 0)
            begin
                write_register(($urandom_range(0, 1) == 0) ? REG_UNUSED_2 : REG_UNUSED_3,
                               $urandom);
            end
            queue_phase_stream($urandom_range(40, 110));
            wait_until_quiet();
            phase++;
        end

        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a block that stops responding.
    initial
    begin
        #(TIMEOUT_UNITS);
        $display("status: fail");
        $finish;
    end

endmodule
